// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the core modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising edge, off during reset.
`define PIE_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define PIE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PIE_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/pie_pkg.sv =====
`timescale 1ns / 1ps
package pie_pkg;

  localparam int ACC_W          = 64;
  localparam int MAX_DIM_DEF    = 16;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 24;
  localparam int RESULT_CAP     = 16;

  localparam logic [1:0] OP_LOAD_MATRIX = 2'd0;
  localparam logic [1:0] OP_LOAD_VECTOR = 2'd1;
  localparam logic [1:0] OP_START       = 2'd2;

  localparam logic [1:0] REG_DIMENSION  = 2'd0;
  localparam logic [1:0] REG_TOLERANCE  = 2'd1;
  localparam logic [1:0] REG_MAX_ITER   = 2'd2;

  localparam logic [4:0]  DIMENSION_RST = 5'd3;
  localparam logic [30:0] TOLERANCE_RST = 31'd17;   // about 1e-6 in Q8.24
  localparam logic [7:0]  MAX_ITER_RST  = 8'd100;

  typedef struct packed {
    logic go;
    logic sqrt_mode;
  } ds_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ds_stat_t;

  function automatic logic signed [ACC_W-1:0] add_sat(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      add_sat = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      add_sat = s[ACC_W-1:0];
    end
  endfunction

endpackage

// ===== rtl/core/pie_ram.sv =====
`timescale 1ns / 1ps
module pie_ram #(
  parameter int WIDTH = pie_pkg::DATA_WIDTH_DEF,
  parameter int DEPTH = pie_pkg::MAX_DIM_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/pie_divsqrt.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Radix-2 restoring divider (num * 2^F / den) and digit-by-digit square root
// (floor(sqrt(s * 2^F))), one bit per cycle on a shared remainder.
module pie_divsqrt #(
  parameter int FRAC_BITS = pie_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  pie_pkg::ds_ctl_t                 ctl,
  input  logic signed [pie_pkg::ACC_W-1:0] num,
  input  logic signed [pie_pkg::ACC_W-1:0] den,
  output pie_pkg::ds_stat_t                stat,
  output logic signed [pie_pkg::ACC_W-1:0] result
);

  localparam int AW        = pie_pkg::ACC_W;
  localparam int DIV_STEPS = AW + FRAC_BITS;
  localparam int SH_W      = (DIV_STEPS % 2 == 1) ? DIV_STEPS + 1 : DIV_STEPS;
  localparam int PAD       = SH_W - DIV_STEPS;
  localparam int SQ_STEPS  = SH_W / 2;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);
  localparam int RW        = AW + 2;

  logic             running;
  logic             done;
  logic             sqrt_mode;
  logic             over;
  logic             neg;
  logic [CNT_W-1:0] cnt;
  logic [SH_W-1:0]  sh;
  logic [RW-1:0]    rem;
  logic [AW-1:0]    q;
  logic [AW-1:0]    dmag;

  logic [AW-1:0]    num_mag;
  logic [AW-1:0]    den_mag;
  logic [RW-1:0]    r_div;
  logic [RW-1:0]    r_sq;
  logic [RW-1:0]    trial;
  logic [AW-1:0]    mag;

  assign num_mag = num[AW-1] ? (~num + 1'b1) : num;
  assign den_mag = den[AW-1] ? (~den + 1'b1) : den;
  assign r_div   = {rem[RW-2:0], sh[SH_W-1]};
  assign r_sq    = {rem[RW-3:0], sh[SH_W-1:SH_W-2]};
  assign trial   = {q, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= running && (cnt == CNT_W'(1));
      if (ctl.go) begin
        running   <= 1'b1;
        sqrt_mode <= ctl.sqrt_mode;
        rem       <= '0;
        q         <= '0;
        over      <= 1'b0;
        dmag      <= den_mag;
        if (ctl.sqrt_mode) begin
          // negative sums never occur; treat as zero
          sh  <= SH_W'({(num[AW-1] ? {AW{1'b0}} : num), {FRAC_BITS{1'b0}}});
          neg <= 1'b0;
          cnt <= CNT_W'(SQ_STEPS);
        end else begin
          sh  <= SH_W'({num_mag, {FRAC_BITS{1'b0}}}) << PAD;
          neg <= num[AW-1] ^ den[AW-1];
          cnt <= CNT_W'(DIV_STEPS);
        end
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
        end
        if (sqrt_mode) begin
          sh <= sh << 2;
          if (r_sq >= trial) begin
            rem <= r_sq - trial;
            q   <= {q[AW-2:0], 1'b1};
          end else begin
            rem <= r_sq;
            q   <= {q[AW-2:0], 1'b0};
          end
        end else begin
          sh   <= sh << 1;
          over <= over | q[AW-1];
          if (r_div >= {2'b00, dmag}) begin
            rem <= r_div - {2'b00, dmag};
            q   <= {q[AW-2:0], 1'b1};
          end else begin
            rem <= r_div;
            q   <= {q[AW-2:0], 1'b0};
          end
        end
      end
    end
  end

  // clamp quotient to the largest positive value, then apply the sign
  always_comb begin
    mag = q;
    if ((!sqrt_mode && over) || q[AW-1]) begin
      mag = {1'b0, {(AW-1){1'b1}}};
    end
    result = neg ? -$signed(mag) : $signed(mag);
  end

  assign stat.busy = running;
  assign stat.done = done;

  `PIE_ASSERT(a_ds_no_go_busy, clk, rst, !(ctl.go && running), "divsqrt started while busy")
  `PIE_ASSERT_NXT(a_ds_done_pulse, clk, rst, done, !done, "divsqrt done longer than one cycle")
  `PIE_ASSERT_IMP(a_ds_done_after_run, clk, rst, done, $past(running), "done without a run")

endmodule

// ===== rtl/core/power_iteration_eigen.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Dominant eigenvalue by power iteration, signed Q(DATA_WIDTH-FRAC_BITS).FRAC_BITS.
// Command channel: a beat is taken on a rising edge with start high and busy low.
//   operation load-matrix / load-vector writes one element (taken every cycle while
//   busy is low). Operation start normalises the vector and iterates y = A*x,
//   lambda = y.y/y.x until |lambda - previous| < tolerance, max_iterations runs or a
//   zero y.x or norm faults; busy is high throughout. Operation 3 is dropped.
// Result channel: one beat per vector element (dimension beats, 0 read as 1, capped
//   at the smaller of 16 and MAX_DIM), each shown for exactly one cycle with
//   result_valid; beats never come back to back and the last carries last. The
//   receiver cannot stall; results are never held.
// Datapath: one shared multiplier and one bit-serial divide/sqrt unit serve the run.
// Config: plain write port (cfg_write, cfg_index, cfg_data), written while idle; the
//   block itself does not enforce this, so keeping to it is up to the user.
// Reset (rst, synchronous): registers return to dimension 3, tolerance 17,
//   max_iterations 100; stores keep contents and read as undefined until loaded.
module power_iteration_eigen #(
  parameter int MAX_DIM    = pie_pkg::MAX_DIM_DEF,
  parameter int DATA_WIDTH = pie_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = pie_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // command channel
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         operation,
  input  logic [3:0]         row_index,
  input  logic [3:0]         col_index,
  input  logic signed [31:0] value,
  // configuration
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  // results
  output logic               result_valid,
  output logic signed [31:0] eigenvalue,
  output logic [7:0]         iterations_used,
  output logic               converged,
  output logic               fault,
  output logic [3:0]         element_index,
  output logic signed [31:0] element_value,
  output logic               last
);

  localparam int AW    = pie_pkg::ACC_W;
  localparam int DW    = DATA_WIDTH;
  localparam int IDX_W = $clog2(MAX_DIM);
  localparam int MA_W  = $clog2(MAX_DIM * MAX_DIM);
  localparam int PW    = (2 * DW > AW) ? 2 * DW : AW;
  localparam int N_CAP = (MAX_DIM < pie_pkg::RESULT_CAP) ? MAX_DIM : pie_pkg::RESULT_CAP;
  localparam logic signed [AW-1:0] DMAX64 = {{(AW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [AW-1:0] DMIN64 = ~DMAX64;

  // sequencer codes
  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_NR   = 5'd1;   // norm of start vector
  localparam logic [4:0] S_NM   = 5'd2;
  localparam logic [4:0] S_NA   = 5'd3;
  localparam logic [4:0] S_NS   = 5'd4;
  localparam logic [4:0] S_NW   = 5'd5;
  localparam logic [4:0] S_VR   = 5'd6;   // x = src / norm
  localparam logic [4:0] S_VD   = 5'd7;
  localparam logic [4:0] S_VW   = 5'd8;
  localparam logic [4:0] S_IT   = 5'd9;
  localparam logic [4:0] S_MR   = 5'd10;  // y = A*x
  localparam logic [4:0] S_MM   = 5'd11;
  localparam logic [4:0] S_MA   = 5'd12;
  localparam logic [4:0] S_DR   = 5'd13;  // y.y and y.x
  localparam logic [4:0] S_DM   = 5'd14;
  localparam logic [4:0] S_DA1  = 5'd15;
  localparam logic [4:0] S_DA2  = 5'd16;
  localparam logic [4:0] S_CK   = 5'd17;
  localparam logic [4:0] S_LW   = 5'd18;
  localparam logic [4:0] S_QW   = 5'd19;
  localparam logic [4:0] S_ER   = 5'd20;  // emit
  localparam logic [4:0] S_EO   = 5'd21;

  function automatic logic signed [DW-1:0] sat_d(input logic signed [AW-1:0] x);
    if (x > DMAX64) begin
      sat_d = DMAX64[DW-1:0];
    end else if (x < DMIN64) begin
      sat_d = DMIN64[DW-1:0];
    end else begin
      sat_d = x[DW-1:0];
    end
  endfunction

  // config registers
  logic [4:0]  dimension;
  logic [30:0] tolerance;
  logic [7:0]  max_iterations;

  always_ff @(posedge clk) begin
    if (rst) begin
      dimension      <= pie_pkg::DIMENSION_RST;
      tolerance      <= pie_pkg::TOLERANCE_RST;
      max_iterations <= pie_pkg::MAX_ITER_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        pie_pkg::REG_DIMENSION: dimension      <= cfg_data[4:0];
        pie_pkg::REG_TOLERANCE: tolerance      <= cfg_data;
        pie_pkg::REG_MAX_ITER:  max_iterations <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // sequencer and working registers
  logic [4:0]              state;
  logic [IDX_W-1:0]        i;
  logic [IDX_W-1:0]        j;
  logic [IDX_W-1:0]        n_last;
  logic [7:0]              m;
  logic [7:0]              iter;
  logic                    from_p;
  logic                    conv;
  logic                    flt;
  logic signed [DW-1:0]    lambda;
  logic signed [DW-1:0]    prev;
  logic signed [AW-1:0]    norm;
  logic signed [AW-1:0]    acc0;
  logic signed [AW-1:0]    acc1;

  logic                    accept;
  logic signed [DW-1:0]    val_sat;
  logic [IDX_W-1:0]        n_last_cfg;
  logic [31:0]             n_tmp;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign val_sat = sat_d(AW'(value));

  always_comb begin
    n_tmp = (dimension == 5'd0) ? 32'd1 : 32'(dimension);
    if (n_tmp > 32'(N_CAP)) begin
      n_tmp = 32'(N_CAP);
    end
    n_last_cfg = IDX_W'(n_tmp - 32'd1);
  end

  // stores
  logic                 m_we;
  logic [MA_W-1:0]      m_waddr;
  logic [MA_W-1:0]      m_raddr;
  logic signed [DW-1:0] m_rd;
  logic                 v_we;
  logic [IDX_W-1:0]     v_waddr;
  logic signed [DW-1:0] v_wdata;
  logic [IDX_W-1:0]     v_raddr;
  logic signed [DW-1:0] v_rd;
  logic                 p_we;
  logic signed [DW-1:0] p_wdata;
  logic signed [DW-1:0] p_rd;

  // divide / sqrt unit
  pie_pkg::ds_ctl_t     ds_ctl;
  pie_pkg::ds_stat_t    ds_stat;
  logic signed [AW-1:0] ds_num;
  logic signed [AW-1:0] ds_den;
  logic signed [AW-1:0] ds_res;

  // shared multiplier
  logic signed [DW-1:0] mul_a;
  logic signed [DW-1:0] mul_b;
  logic [DW-1:0]        a_mag;
  logic [DW-1:0]        b_mag;
  logic [2*DW-1:0]      pmag;
  logic                 psign;
  logic [PW-1:0]        pshift;
  logic [AW-1:0]        mmag;
  logic signed [AW-1:0] mq;
  logic signed [AW-1:0] acc_next;

  // convergence test
  logic signed [DW-1:0] lam_new;
  logic signed [DW:0]   ldiff;
  logic [DW:0]          ldabs;
  logic                 conv_now;

  assign m_we    = accept && (operation == pie_pkg::OP_LOAD_MATRIX)
                   && (32'(row_index) < 32'(MAX_DIM)) && (32'(col_index) < 32'(MAX_DIM));
  assign m_waddr = MA_W'(32'(row_index) * 32'(MAX_DIM) + 32'(col_index));
  assign m_raddr = MA_W'(32'(i) * 32'(MAX_DIM) + 32'(j));

  always_comb begin
    if (state == S_VW) begin
      v_we    = ds_stat.done;
      v_waddr = i;
      v_wdata = sat_d(ds_res);
    end else begin
      v_we    = accept && (operation == pie_pkg::OP_LOAD_VECTOR)
                && (32'(row_index) < 32'(MAX_DIM));
      v_waddr = IDX_W'(row_index);
      v_wdata = val_sat;
    end
  end
  assign v_raddr = (state == S_MR) ? j : i;

  assign acc_next = pie_pkg::add_sat(acc0, mq);
  assign p_we     = (state == S_MA) && (j == n_last);
  assign p_wdata  = sat_d(acc_next);

  pie_ram #(.WIDTH(DW), .DEPTH(MAX_DIM * MAX_DIM)) u_mat (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(val_sat),
    .raddr(m_raddr), .rdata(m_rd)
  );

  pie_ram #(.WIDTH(DW), .DEPTH(MAX_DIM)) u_vec (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
    .raddr(v_raddr), .rdata(v_rd)
  );

  pie_ram #(.WIDTH(DW), .DEPTH(MAX_DIM)) u_prod (
    .clk(clk), .we(p_we), .waddr(i), .wdata(p_wdata),
    .raddr(i), .rdata(p_rd)
  );

  // multiplier: magnitude product registered, shift and clamp after
  assign mul_a = (state == S_MM) ? m_rd : ((state == S_NM) ? v_rd : p_rd);
  assign mul_b = (state == S_DM) ? p_rd : v_rd;
  assign a_mag = mul_a[DW-1] ? (~mul_a + 1'b1) : mul_a;
  assign b_mag = mul_b[DW-1] ? (~mul_b + 1'b1) : mul_b;

  always_ff @(posedge clk) begin
    pmag  <= a_mag * b_mag;
    psign <= mul_a[DW-1] ^ mul_b[DW-1];
  end

  always_comb begin
    pshift = PW'(pmag) >> FRAC_BITS;
    if (|pshift[PW-1:AW-1]) begin
      mmag = {1'b0, {(AW-1){1'b1}}};
    end else begin
      mmag = {1'b0, pshift[AW-2:0]};
    end
    mq = psign ? -$signed(mmag) : $signed(mmag);
  end

  // lambda and its change
  assign lam_new  = sat_d(ds_res);
  assign ldiff    = {prev[DW-1], prev} - {lam_new[DW-1], lam_new};
  assign ldabs    = ldiff[DW] ? (~ldiff + 1'b1) : ldiff;
  assign conv_now = (AW + 1)'(ldabs) < (AW + 1)'(tolerance);

  // divider operands follow the sequencer
  assign ds_num = (state == S_VD) ? AW'(from_p ? p_rd : v_rd) : acc0;
  assign ds_den = (state == S_VD) ? norm : acc1;
  assign ds_ctl.go = (state == S_NS) || (state == S_VD)
                     || ((state == S_CK) && (acc1 != '0))
                     || ((state == S_LW) && ds_stat.done && !conv_now);
  assign ds_ctl.sqrt_mode = (state == S_NS) || (state == S_LW);

  pie_divsqrt #(.FRAC_BITS(FRAC_BITS)) u_ds (
    .clk(clk), .rst(rst), .ctl(ds_ctl), .num(ds_num), .den(ds_den),
    .stat(ds_stat), .result(ds_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && (operation == pie_pkg::OP_START)) begin
            n_last <= n_last_cfg;
            i      <= '0;
            m      <= '0;
            iter   <= '0;
            conv   <= 1'b0;
            flt    <= 1'b0;
            lambda <= '0;
            prev   <= '0;
            acc0   <= '0;
            state  <= S_NR;
          end
        end
        S_NR: state <= S_NM;
        S_NM: state <= S_NA;
        S_NA: begin
          acc0 <= acc_next;
          if (i == n_last) begin
            state <= S_NS;
          end else begin
            i     <= i + 1'b1;
            state <= S_NR;
          end
        end
        S_NS: state <= S_NW;
        S_NW: begin
          if (ds_stat.done) begin
            i <= '0;
            if (ds_res == '0) begin
              // start vector norm is zero: report and emit the vector untouched
              flt    <= 1'b1;
              lambda <= DMAX64[DW-1:0];
              state  <= S_ER;
            end else begin
              norm   <= ds_res;
              from_p <= 1'b0;
              state  <= S_VR;
            end
          end
        end
        S_VR: state <= S_VD;
        S_VD: state <= S_VW;
        S_VW: begin
          if (ds_stat.done) begin
            if (i == n_last) begin
              if (from_p) begin
                m <= m + 1'b1;
              end
              state <= S_IT;
            end else begin
              i     <= i + 1'b1;
              state <= S_VR;
            end
          end
        end
        S_IT: begin
          i <= '0;
          j <= '0;
          acc0 <= '0;
          if (m == max_iterations) begin
            state <= S_ER;
          end else begin
            state <= S_MR;
          end
        end
        S_MR: state <= S_MM;
        S_MM: state <= S_MA;
        S_MA: begin
          if (j == n_last) begin
            j    <= '0;
            acc0 <= '0;
            acc1 <= '0;
            if (i == n_last) begin
              i     <= '0;
              state <= S_DR;
            end else begin
              i     <= i + 1'b1;
              state <= S_MR;
            end
          end else begin
            acc0  <= acc_next;
            j     <= j + 1'b1;
            state <= S_MR;
          end
        end
        S_DR: state <= S_DM;
        S_DM: state <= S_DA1;
        S_DA1: begin
          acc0  <= acc_next;
          state <= S_DA2;
        end
        S_DA2: begin
          acc1 <= pie_pkg::add_sat(acc1, mq);
          if (i == n_last) begin
            state <= S_CK;
          end else begin
            i     <= i + 1'b1;
            state <= S_DR;
          end
        end
        S_CK: begin
          iter <= m;
          i    <= '0;
          if (acc1 == '0) begin
            flt    <= 1'b1;
            lambda <= DMAX64[DW-1:0];
            state  <= S_ER;
          end else begin
            state <= S_LW;
          end
        end
        S_LW: begin
          if (ds_stat.done) begin
            lambda <= lam_new;
            if (conv_now) begin
              conv  <= 1'b1;
              state <= S_ER;
            end else begin
              prev  <= lam_new;
              state <= S_QW;
            end
          end
        end
        S_QW: begin
          if (ds_stat.done) begin
            if (ds_res == '0) begin
              flt   <= 1'b1;
              state <= S_ER;
            end else begin
              norm   <= ds_res;
              from_p <= 1'b1;
              state  <= S_VR;
            end
          end
        end
        S_ER: state <= S_EO;
        S_EO: begin
          result_valid    <= 1'b1;
          eigenvalue      <= 32'(lambda);
          iterations_used <= iter;
          converged       <= conv;
          fault           <= flt;
          element_index   <= 4'(i);
          element_value   <= 32'(v_rd);
          last            <= (i == n_last);
          if (i == n_last) begin
            state <= S_IDLE;
          end else begin
            i     <= i + 1'b1;
            state <= S_ER;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PIE_ASSERT_IMP(a_beat_from_emit, clk, rst, result_valid, $past(state) == S_EO, "result beat outside emit")
  `PIE_ASSERT_IMP(a_idle_after_last, clk, rst, $fell(busy) && !$past(rst), result_valid && last, "run ended without last beat")
  `PIE_ASSERT_NXT(a_beat_spacing, clk, rst, result_valid && !last, !result_valid, "result beats back to back")

endmodule

// ===== bench/tb_power_iteration_eigen.sv =====
`timescale 1ns / 1ps
module tb_power_iteration_eigen;

  // Longest stretch with no beat accepted on any side before we give up.
  // Worst case is dimension 4 at 255 iterations.
  localparam int WATCHDOG_LIMIT = 1000000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int RAND_PHASES    = 8;
  localparam int PHASE_ITEMS    = 10;
  localparam int FIXED_ITEMS    = 6;
  localparam longint DMAX       = 64'sd2147483647;
  localparam longint DMIN       = -64'sd2147483648;
  localparam longint WMAX       = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam longint WMIN       = 64'h8000_0000_0000_0000;
  localparam logic [1:0] OP_NONE = 2'd3;   // undefined operation, dropped

  typedef struct {
    logic signed [31:0] eig;
    logic [7:0]         iters;
    logic               conv;
    logic               flt;
    logic [3:0]         idx;
    logic signed [31:0] elem;
    logic               lst;
  } eig_beat_t;

  // One command beat; typed rows carry the eigenvalue and fault read off directly.
  typedef struct {
    logic [1:0]  op;
    logic [3:0]  r;
    logic [3:0]  c;
    logic [31:0] v;
    bit          typed;
    logic [31:0] t_eig;
    logic        t_flt;
  } cmd_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         operation = '0;
  logic [3:0]         row_index = '0;
  logic [3:0]         col_index = '0;
  logic signed [31:0] value = '0;
  logic               cfg_write = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [30:0]        cfg_data = '0;
  logic               result_valid;
  logic signed [31:0] eigenvalue;
  logic [7:0]         iterations_used;
  logic               converged;
  logic               fault;
  logic [3:0]         element_index;
  logic signed [31:0] element_value;
  logic               last;

  power_iteration_eigen u_top (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy), .operation(operation),
    .row_index(row_index), .col_index(col_index), .value(value),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result_valid(result_valid), .eigenvalue(eigenvalue),
    .iterations_used(iterations_used), .converged(converged), .fault(fault),
    .element_index(element_index), .element_value(element_value), .last(last)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the solver: stores, registers, and the beats still to come.
  // ---------------------------------------------------------------------------
  longint    mat_q [256];
  longint    vec_q [16];
  bit        mat_ok [256];
  bit        vec_ok [16];
  int        dim_reg;
  longint    tol_reg;
  int        maxit_reg;
  eig_beat_t pending_beats [$];
  int        errors = 0;

  function automatic longint clamp32(input longint v);
    if (v > DMAX) return DMAX;
    if (v < DMIN) return DMIN;
    return v;
  endfunction

  function automatic longint sat_add(input longint a, input longint b);
    logic signed [64:0] s;
    s = a + b;
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return WMAX;
    if (s < -65'sh0_8000_0000_0000_0000) return WMIN;
    return longint'(s[63:0]);
  endfunction

  // Q product: exact, truncated toward zero, magnitude capped at 64-bit max.
  function automatic longint q_mul(input longint a, input longint b);
    logic [63:0]  ua, ub, m;
    logic [127:0] p;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    p  = {64'd0, ua} * {64'd0, ub};
    m  = (p[127:88] != 0) ? 64'(WMAX) : p[87:24];
    if (m > 64'(WMAX)) m = 64'(WMAX);
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint q_div(input longint num, input longint den);
    logic [63:0] un, ud;
    logic [87:0] q;
    un = (num < 0) ? -num : num;
    ud = (den < 0) ? -den : den;
    q  = {un, 24'd0} / {24'd0, ud};
    if (q > 88'(WMAX)) q = 88'(WMAX);
    return ((num < 0) != (den < 0)) ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  // floor(sqrt(s * 2^24)), bit by bit
  function automatic longint q_sqrt(input longint s);
    logic [87:0] x;
    logic [43:0] root, t;
    x    = (s < 0) ? 88'd0 : {64'(s), 24'd0};
    root = '0;
    for (int b = 43; b >= 0; b--) begin
      t = root | (44'd1 << b);
      if ({44'd0, t} * {44'd0, t} <= x) root = t;
    end
    return longint'({20'd0, root});
  endfunction

  function automatic int active_dim();
    if (dim_reg == 0) return 1;
    if (dim_reg > 16) return 16;
    return dim_reg;
  endfunction

  // every entry a start of this order would read has been loaded
  function automatic bit stores_ready();
    int n;
    n = active_dim();
    for (int i = 0; i < n; i++) begin
      if (!vec_ok[i]) return 0;
      for (int j = 0; j < n; j++) begin
        if (!mat_ok[i*16+j]) return 0;
      end
    end
    return 1;
  endfunction

  task automatic solve_dominant(input cmd_t cmd);
    int        n, itc;
    longint    acc, s, c, lam, prev, nrm, diff;
    longint    y [16];
    bit        conv, flt;
    eig_beat_t b;
    n    = active_dim();
    prev = 0;
    itc  = 0;
    lam  = 0;
    conv = 0;
    flt  = 0;
    acc  = 0;
    for (int i = 0; i < n; i++) acc = sat_add(acc, q_mul(vec_q[i], vec_q[i]));
    nrm = q_sqrt(acc);
    if (nrm == 0) begin
      // start vector norm is zero: nothing is normalised, vector goes out as loaded
      flt = 1;
      lam = DMAX;
    end else begin
      for (int i = 0; i < n; i++) vec_q[i] = clamp32(q_div(vec_q[i], nrm));
      for (int m = 0; m < maxit_reg; m++) begin
        for (int i = 0; i < n; i++) begin
          acc = 0;
          for (int j = 0; j < n; j++) acc = sat_add(acc, q_mul(mat_q[i*16+j], vec_q[j]));
          y[i] = clamp32(acc);
        end
        s = 0;
        c = 0;
        for (int i = 0; i < n; i++) begin
          s = sat_add(s, q_mul(y[i], y[i]));
          c = sat_add(c, q_mul(y[i], vec_q[i]));
        end
        itc = m;
        if (c == 0) begin
          flt = 1;
          lam = DMAX;
          break;
        end
        lam  = clamp32(q_div(s, c));
        diff = (prev >= lam) ? prev - lam : lam - prev;
        if (diff < tol_reg) begin
          conv = 1;
          break;
        end
        prev = lam;
        nrm  = q_sqrt(s);
        if (nrm == 0) begin
          flt = 1;
          break;
        end
        for (int i = 0; i < n; i++) vec_q[i] = clamp32(q_div(y[i], nrm));
      end
    end
    for (int i = 0; i < n; i++) begin
      b.eig   = cmd.typed ? cmd.t_eig : lam[31:0];
      b.iters = itc[7:0];
      b.conv  = conv;
      b.flt   = cmd.typed ? cmd.t_flt : flt;
      b.idx   = i[3:0];
      b.elem  = vec_q[i][31:0];
      b.lst   = (i == n - 1);
      pending_beats.push_back(b);
    end
  endtask

  task automatic apply_cmd(input cmd_t cmd);
    case (cmd.op)
      pie_pkg::OP_LOAD_MATRIX: begin
        mat_q[cmd.r*16+cmd.c]  = longint'(signed'(cmd.v));
        mat_ok[cmd.r*16+cmd.c] = 1;
      end
      pie_pkg::OP_LOAD_VECTOR: begin
        vec_q[cmd.r]  = longint'(signed'(cmd.v));
        vec_ok[cmd.r] = 1;
      end
      pie_pkg::OP_START: solve_dominant(cmd);
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Command side. start stays high across back-to-back beats; it is only
  // lowered when a gap follows, so it never sees two NBAs in one step.
  // ---------------------------------------------------------------------------
  task automatic send_cmd(input cmd_t cmd, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    operation <= cmd.op;
    row_index <= cmd.r;
    col_index <= cmd.c;
    value     <= cmd.v;
    do @(posedge clk); while (busy);
    apply_cmd(cmd);
  endtask

  // Registers only change once the solver is quiet: every beat in, busy low,
  // then a little slack for a trailing load.
  task automatic program_regs(input int dim, input longint tol, input int maxit);
    start <= 1'b0;
    @(posedge clk);
    while (pending_beats.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= pie_pkg::REG_DIMENSION;
    cfg_data  <= 31'(dim);
    @(posedge clk);
    cfg_index <= pie_pkg::REG_TOLERANCE;
    cfg_data  <= 31'(tol);
    @(posedge clk);
    cfg_index <= pie_pkg::REG_MAX_ITER;
    cfg_data  <= 31'(maxit);
    @(posedge clk);
    cfg_write <= 1'b0;
    dim_reg   = dim;
    tol_reg   = tol;
    maxit_reg = maxit;
  endtask

  function automatic logic [31:0] rand_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;  // about +/-2.0
    if (r < 82) return $urandom();
    if (r < 92) return 32'd0;
    return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t cmd;
    int   r, n;
    bit   ok;
    n         = active_dim();
    ok        = stores_ready();
    r         = $urandom_range(0, 99);
    cmd.typed = 0;
    cmd.t_eig = '0;
    cmd.t_flt = 0;
    cmd.r     = 4'($urandom_range(0, 15));
    cmd.c     = 4'($urandom_range(0, 15));
    cmd.v     = rand_value();
    if (r < 4) begin
      cmd.op = OP_NONE;
    end else if (r < 16 && ok) begin
      cmd.op = pie_pkg::OP_START;
    end else if (!ok) begin
      // fill the first hole in the active block, vector holes before matrix ones
      cmd.op = pie_pkg::OP_LOAD_MATRIX;
      for (int k = n*n - 1; k >= 0; k--) begin
        if (!mat_ok[(k/n)*16 + k%n]) begin
          cmd.r = 4'(k / n);
          cmd.c = 4'(k % n);
        end
      end
      for (int k = n - 1; k >= 0; k--) begin
        if (!vec_ok[k]) begin
          cmd.op = pie_pkg::OP_LOAD_VECTOR;
          cmd.r  = 4'(k);
        end
      end
    end else begin
      cmd.op = ($urandom_range(0, 1) != 0) ? pie_pkg::OP_LOAD_MATRIX
                                            : pie_pkg::OP_LOAD_VECTOR;
      if ($urandom_range(0, 9) < 8) begin
        cmd.r = 4'($urandom_range(0, n - 1));
        cmd.c = 4'($urandom_range(0, n - 1));
      end
    end
    return cmd;
  endfunction

  // A phase: random beats, then fill any holes and finish on a start.
  task automatic run_phase(input int items);
    cmd_t cmd;
    bit   no_gaps;
    no_gaps = ($urandom_range(0, 3) == 0);
    for (int k = 0; k < items; k++) begin
      cmd = rand_cmd();
      send_cmd(cmd, no_gaps ? 0 : $urandom_range(0, 9));
    end
    while (!stores_ready()) begin
      cmd = rand_cmd();
      if (cmd.op != pie_pkg::OP_START) send_cmd(cmd, no_gaps ? 0 : $urandom_range(0, 9));
    end
    cmd    = rand_cmd();
    cmd.op = pie_pkg::OP_START;
    send_cmd(cmd, $urandom_range(0, 9));
  endtask

  cmd_t directed [$];

  initial begin
    int dim, maxit;
    longint tol;
    for (int i = 0; i < 256; i++) begin
      mat_q[i]  = 0;
      mat_ok[i] = 0;
    end
    for (int i = 0; i < 16; i++) begin
      vec_q[i]  = 0;
      vec_ok[i] = 0;
    end
    dim_reg   = pie_pkg::DIMENSION_RST;
    tol_reg   = pie_pkg::TOLERANCE_RST;
    maxit_reg = pie_pkg::MAX_ITER_RST;

    // zero start vector: fault, eigenvalue pinned at full scale
    directed.push_back('{pie_pkg::OP_LOAD_VECTOR, 4'd0, 4'd0, 32'd0, 0, 32'd0, 1'b0});
    directed.push_back('{pie_pkg::OP_LOAD_VECTOR, 4'd1, 4'd0, 32'd0, 0, 32'd0, 1'b0});
    directed.push_back('{pie_pkg::OP_LOAD_VECTOR, 4'd2, 4'd0, 32'd0, 0, 32'd0, 1'b0});
    directed.push_back('{pie_pkg::OP_START, 4'd0, 4'd0, 32'd0, 1, 32'h7FFF_FFFF, 1'b1});
    // zero matrix, unit vector: y.x is zero, fault again
    directed.push_back('{pie_pkg::OP_LOAD_VECTOR, 4'd0, 4'd0, 32'h0100_0000, 0, 32'd0, 1'b0});
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        directed.push_back('{pie_pkg::OP_LOAD_MATRIX, 4'(i), 4'(j), 32'd0, 0, 32'd0, 1'b0});
      end
    end
    directed.push_back('{pie_pkg::OP_START, 4'd0, 4'd0, 32'd0, 1, 32'h7FFF_FFFF, 1'b1});
    // diagonal with both extremes on the data path
    directed.push_back('{pie_pkg::OP_LOAD_MATRIX, 4'd0, 4'd0, 32'h0200_0000, 0, 32'd0, 1'b0});
    directed.push_back('{pie_pkg::OP_LOAD_MATRIX, 4'd1, 4'd1, 32'h0100_0000, 0, 32'd0, 1'b0});
    directed.push_back('{pie_pkg::OP_LOAD_MATRIX, 4'd2, 4'd2, 32'h8000_0000, 0, 32'd0, 1'b0});
    directed.push_back('{pie_pkg::OP_LOAD_VECTOR, 4'd1, 4'd0, 32'h7FFF_FFFF, 0, 32'd0, 1'b0});
    directed.push_back('{pie_pkg::OP_LOAD_VECTOR, 4'd2, 4'd0, 32'hFFFF_FFFF, 0, 32'd0, 1'b0});
    directed.push_back('{OP_NONE, 4'd15, 4'd15, 32'h8000_0000, 0, 32'd0, 1'b0});
    directed.push_back('{pie_pkg::OP_LOAD_MATRIX, 4'd15, 4'd15, 32'h7FFF_FFFF, 0, 32'd0, 1'b0});
    directed.push_back('{pie_pkg::OP_LOAD_VECTOR, 4'd15, 4'd0, 32'h8000_0000, 0, 32'd0, 1'b0});
    directed.push_back('{pie_pkg::OP_START, 4'd0, 4'd0, 32'd0, 0, 32'd0, 1'b0});

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[k]) send_cmd(directed[k], $urandom_range(0, 9));

    // Fixed corners: dimension 0 and above range, zero and full tolerance,
    // zero iteration limit, single iteration.
    program_regs(1, 0, 5);
    run_phase(FIXED_ITEMS);
    program_regs(0, 17, 1);
    run_phase(FIXED_ITEMS);
    program_regs(2, 17, 0);
    run_phase(FIXED_ITEMS);
    program_regs(4, 64'h7FFF_FFFF, 255);
    run_phase(FIXED_ITEMS);
    program_regs(31, 100, 2);
    run_phase(FIXED_ITEMS);
    program_regs(16, 17, 1);
    run_phase(FIXED_ITEMS);

    for (int p = 0; p < RAND_PHASES; p++) begin
      case ($urandom_range(0, 9))
        0:       dim = $urandom_range(16, 31);
        1, 2:    dim = $urandom_range(5, 8);
        default: dim = $urandom_range(1, 4);
      endcase
      maxit = (dim <= 4) ? $urandom_range(1, 12) : $urandom_range(1, 3);
      case ($urandom_range(0, 3))
        0:       tol = $urandom_range(0, 32'h0010_0000);
        1:       tol = $urandom_range(0, 32'h7FFF_FFFF);
        default: tol = 17;
      endcase
      program_regs(dim, tol, maxit);
      run_phase(PHASE_ITEMS);
    end

    start <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: each strobed beat against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    eig_beat_t want;
    if (!rst && result_valid) begin
      if (pending_beats.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        want = pending_beats.pop_front();
        if (eigenvalue !== want.eig) begin
          $error("eigenvalue exp %0d got %0d", want.eig, eigenvalue);
          errors++;
        end
        if (iterations_used !== want.iters) begin
          $error("iterations_used exp %0d got %0d", want.iters, iterations_used);
          errors++;
        end
        if (converged !== want.conv) begin
          $error("converged exp %0d got %0d", want.conv, converged);
          errors++;
        end
        if (fault !== want.flt) begin
          $error("fault exp %0d got %0d", want.flt, fault);
          errors++;
        end
        if (element_index !== want.idx) begin
          $error("element_index exp %0d got %0d", want.idx, element_index);
          errors++;
        end
        if (element_value !== want.elem) begin
          $error("element_value exp %0d got %0d", want.elem, element_value);
          errors++;
        end
        if (last !== want.lst) begin
          $error("last exp %0d got %0d", want.lst, last);
          errors++;
        end
      end
    end
  end

  // Watchdog: cycles with no beat taken on any channel.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || cfg_write) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
